// ===== src/msd_pkg.sv =====
// Shared types, constants and decode table for the Morse stream decoder.
package msd_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] letter;
    logic       word_gap;
  } cmd_t;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_NONE  = 8'h00;

  localparam int TABLE_SYMBOLS = 5;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] MORSE_LUT [64] = '{
    8'h00, 8'h00,
    "E", "T",
    "I", "A", "N", "M",
    "S", "U", "R", "W", "D", "K", "G", "O",
    "H", "V", "F", 8'h00, "L", 8'h00, "P", "J",
    "B", "X", "C", "Y", "Z", "Q", 8'h00, 8'h00,
    "5", "4", 8'h00, "3", 8'h00, 8'h00, 8'h00, "2",
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "1",
    "6", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    "7", 8'h00, 8'h00, 8'h00, "8", 8'h00, "9", "0"
  };

  function automatic logic [7:0] lookup_code(input logic [4:0] bits, input logic [3:0] len,
                                             input logic invalid);
    logic [5:0] top;
    logic [4:0] mask;
    logic [5:0] idx;
    top  = 6'd1 << len[2:0];
    mask = 5'(top - 6'd1);
    idx  = top | {1'b0, bits & mask};
    if (invalid || len == 4'd0 || len > 4'(TABLE_SYMBOLS)) begin
      return CHAR_NONE;
    end
    return MORSE_LUT[idx];
  endfunction

endpackage

// ===== src/morse_stream_decoder.sv =====
// Morse stream decoder: one character per transaction in, decoded characters out.
// Each result passes through the command queue and then the registered output stage.
// Throughput: one input per cycle while the queue has room; a slash that ends a letter
// gives two results, sent one after the other while a 4-entry queue absorbs input.
// Reset (rst, synchronous): clears the pending code, the queue and the output stage.
module morse_stream_decoder #(
  parameter int MAX_SYMBOLS = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  msd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output msd_pkg::out_item_t out_data
);

  logic          fq_valid, fq_ready, qb_valid, qb_ready;
  msd_pkg::cmd_t fq_data, qb_data;

  msd_front #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd_data  (fq_data)
  );

  msd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  msd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd_data  (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/msd_front.sv =====
// Front end: accept characters, track the pending code, issue decode commands.
module msd_front #(
  parameter int MAX_SYMBOLS = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  msd_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output msd_pkg::cmd_t     cmd_data
);

  localparam int LW = $clog2(MAX_SYMBOLS + 1);

  logic [MAX_SYMBOLS-1:0] code_bits, code_bits_next, sym_bits;
  logic [LW-1:0]          code_length, code_length_next, sym_length;
  logic                   code_invalid, code_invalid_next, sym_invalid;
  logic                   is_sym, is_gap, is_slash, accept;
  logic [7:0]             letter_gap, letter_eom;
  logic [7:0]             cur_bits8, sym_bits8;

  assign is_sym   = (in_data.in_char == msd_pkg::CHAR_DOT) ||
                    (in_data.in_char == msd_pkg::CHAR_DASH);
  assign is_slash = in_data.in_char == msd_pkg::CHAR_SLASH;
  assign is_gap   = (in_data.in_char == msd_pkg::CHAR_SPACE) || is_slash;
  assign in_ready = cmd_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    sym_bits    = code_bits;
    sym_length  = code_length;
    sym_invalid = code_invalid;
    priority if (is_sym) begin
      if (code_length >= LW'(MAX_SYMBOLS)) begin
        sym_invalid = 1'b1;
      end else begin
        sym_bits   = {code_bits[MAX_SYMBOLS-2:0],
                      in_data.in_char == msd_pkg::CHAR_DASH};
        sym_length = code_length + LW'(1);
      end
    end else if (is_gap) begin
      sym_bits    = '0;
      sym_length  = '0;
      sym_invalid = 1'b0;
    end else begin
      sym_invalid = 1'b1;
    end
  end

  assign cur_bits8  = 8'(code_bits);
  assign sym_bits8  = 8'(sym_bits);
  assign letter_gap = msd_pkg::lookup_code(cur_bits8[4:0], 4'(code_length), code_invalid);
  assign letter_eom = msd_pkg::lookup_code(sym_bits8[4:0], 4'(sym_length), sym_invalid);

  always_comb begin
    cmd_data.word_gap = is_slash;
    if (is_gap) begin
      cmd_data.letter = letter_gap;
    end else if (in_data.end_of_message) begin
      cmd_data.letter = letter_eom;
    end else begin
      cmd_data.letter = msd_pkg::CHAR_NONE;
    end
    cmd_valid = in_valid && (is_slash || cmd_data.letter != msd_pkg::CHAR_NONE);
  end

  always_comb begin
    code_bits_next    = code_bits;
    code_length_next  = code_length;
    code_invalid_next = code_invalid;
    if (accept) begin
      if (in_data.end_of_message) begin
        code_bits_next    = '0;
        code_length_next  = '0;
        code_invalid_next = 1'b0;
      end else begin
        code_bits_next    = sym_bits;
        code_length_next  = sym_length;
        code_invalid_next = sym_invalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits    <= '0;
      code_length  <= '0;
      code_invalid <= 1'b0;
    end else begin
      code_bits    <= code_bits_next;
      code_length  <= code_length_next;
      code_invalid <= code_invalid_next;
    end
  end

  a_eom_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.end_of_message |=> code_length == '0 && !code_invalid)
    else $error("pending code not cleared after end of message");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    code_length <= LW'(MAX_SYMBOLS))
    else $error("code length out of range");

endmodule

// ===== src/msd_queue.sv =====
// Small command queue between front end and output stage.
module msd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  msd_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output msd_pkg::cmd_t pop_data
);

  msd_pkg::cmd_t                 entries [msd_pkg::QUEUE_DEPTH];
  logic [msd_pkg::QUEUE_AW-1:0]  head, tail;
  logic [msd_pkg::QUEUE_AW:0]    count;
  logic                          do_push, do_pop;

  assign push_ready = count != (msd_pkg::QUEUE_AW+1)'(msd_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[head];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= tail + (msd_pkg::QUEUE_AW)'(1);
      end
      if (do_pop) begin
        head <= head + (msd_pkg::QUEUE_AW)'(1);
      end
      count <= count + (msd_pkg::QUEUE_AW+1)'(do_push) - (msd_pkg::QUEUE_AW+1)'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (msd_pkg::QUEUE_AW+1)'(msd_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count != (msd_pkg::QUEUE_AW+1)'(msd_pkg::QUEUE_DEPTH) |->
      tail - head == count[msd_pkg::QUEUE_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ===== src/msd_back.sv =====
// Output stage: expand commands into result characters and hold them for the sink.
module msd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  msd_pkg::cmd_t      cmd_data,
  output logic               out_valid,
  input  logic               out_ready,
  output msd_pkg::out_item_t out_data
);

  logic load, space_pend;

  assign load      = !out_valid || out_ready;
  assign cmd_ready = load && !space_pend;

  always_ff @(posedge clk) begin
    if (load) begin
      if (space_pend || cmd_data.letter == msd_pkg::CHAR_NONE) begin
        out_data <= '{out_char: msd_pkg::CHAR_SPACE, last_of_run: 1'b1};
      end else begin
        out_data <= '{out_char: cmd_data.letter, last_of_run: !cmd_data.word_gap};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      space_pend <= 1'b0;
    end else if (load) begin
      if (space_pend) begin
        out_valid  <= 1'b1;
        space_pend <= 1'b0;
      end else if (cmd_valid) begin
        out_valid  <= 1'b1;
        space_pend <= cmd_data.word_gap && cmd_data.letter != msd_pkg::CHAR_NONE;
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  a_pend_has_out: assert property (@(posedge clk) disable iff (rst)
    space_pend |-> out_valid && !out_data.last_of_run)
    else $error("pending word gap without a held letter");

  a_no_pop_pend: assert property (@(posedge clk) disable iff (rst)
    space_pend |-> !cmd_ready)
    else $error("command taken while word gap pending");

endmodule
